[hdl/dfc_pkg.sv]
// dfc_pkg: shared types, constants and helpers for the data fetcher coprocessor.
// No dependencies.
package dfc_pkg;
   localparam int DISPLAY_BYTES_DEF = 2048;
   localparam int FRAC_BITS_DEF     = 24;
   localparam int RATIO_W           = 24;
   localparam logic [RATIO_W-1:0] RATIO_RESET = 24'd281216;

   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_LOAD  = 2'd2;
   localparam logic [1:0] MODE_NONE  = 2'd3;

   localparam logic [11:0] HOT_BANK0 = 12'hFF8;
   localparam logic [11:0] HOT_BANK1 = 12'hFF9;
   localparam logic [11:0] REG_LIMIT = 12'h040;
   localparam logic [11:0] WR_LIMIT  = 12'h080;

   localparam logic [2:0] FN_RD_RANDOM = 3'd0;
   localparam logic [2:0] FN_RD_DISP   = 3'd1;
   localparam logic [2:0] FN_RD_MASK   = 3'd2;
   localparam logic [2:0] FN_RD_FLAG   = 3'd7;
   localparam logic [2:0] FN_WR_TOP    = 3'd0;
   localparam logic [2:0] FN_WR_BOT    = 3'd1;
   localparam logic [2:0] FN_WR_LOW    = 3'd2;
   localparam logic [2:0] FN_WR_HIGH   = 3'd3;
   localparam logic [2:0] FN_WR_RESET  = 3'd6;

   // request from the sequencer to the music divider
   typedef struct packed {
      logic        start;
      logic [31:0] whole;
      logic [8:0]  span;
   } mod_req_type;

   typedef struct packed {
      logic       done;
      logic [8:0] rem;
   } mod_rsp_type;

   function automatic logic [7:0] amp_lookup(input logic [2:0] sel);
      logic [7:0] r;
      case (sel)
         3'd0: r = 8'h00;
         3'd1: r = 8'h04;
         3'd2: r = 8'h05;
         3'd3: r = 8'h09;
         3'd4: r = 8'h06;
         3'd5: r = 8'h0a;
         3'd6: r = 8'h0b;
         default: r = 8'h0f;
      endcase
      return r;
   endfunction
endpackage

[hdl/dfc_ram.sv]
// dfc_ram: generic single-port RAM with registered read.
// No dependencies.
module dfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hdl/dfc_modulo.sv]
// dfc_modulo: bit-serial restoring remainder of a 32-bit value by a 9-bit span.
// Depends on dfc_pkg.
module dfc_modulo (
   input  logic                clock,
   input  logic                reset,
   input  dfc_pkg::mod_req_type req,
   output dfc_pkg::mod_rsp_type rsp
);
   import dfc_pkg::*;

   logic [31:0] num_ff, num_in;
   logic [9:0]  rem_ff, rem_in;
   logic [8:0]  span_ff, span_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [9:0]  trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      span_in = span_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[8:0], num_ff[31]};
      if (req.start) begin
         num_in  = req.whole;
         span_in = req.span;
         rem_in  = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[30:0], 1'b0};
         if (trial >= {1'b0, span_ff}) begin
            rem_in = trial - {1'b0, span_ff};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      span_ff <= span_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff[8:0];

   always_ff @(posedge clock) begin
      if (!reset && busy_ff) begin
         assert (rem_ff < {1'b0, span_ff}) else $error("remainder out of range");
      end
   end
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |=> busy_ff) else $error("start did not begin");
   a_cnt_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 6'd0) else $error("busy with zero count");
endmodule

[hdl/data_fetcher_coprocessor_unit.sv]
// data_fetcher_coprocessor_unit: top level with sequencer, fetcher state and display RAM.
// From accept to rsp_valid: S_EXEC, S_RSP for writes, loads and other transactions, plus
// S_RAM for register reads; a music read adds S_MUL_LO, S_MUL_HI, S_SAT, S_CH per channel
// while the clock count is nonzero, S_MOD for an enabled channel with nonzero top (32-step
// remainder) and S_AMP. One transaction at a time; the next is accepted after the response.
// Synchronous active-high reset initialises the fetcher state, not the request registers;
// display memory is undefined until loaded. Depends on dfc_pkg, dfc_ram, dfc_modulo.
module data_fetcher_coprocessor_unit #(
   parameter int DISPLAY_BYTES = dfc_pkg::DISPLAY_BYTES_DEF,
   parameter int FRAC_BITS     = dfc_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_osc_ratio,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [15:0] req_cycles_elapsed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_handled,
   output logic        rsp_current_bank
);
   import dfc_pkg::*;

   localparam int AW = $clog2(DISPLAY_BYTES);
   localparam int PW = 32 + RATIO_W + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_RAM, S_MUL_LO, S_MUL_HI, S_SAT, S_CH, S_MOD, S_AMP, S_RSP
   } state_type;

   state_type state_ff;
   logic [23:0] ratio_ff;
   logic [7:0]  top_ff [8];
   logic [7:0]  bot_ff [8];
   logic [10:0] cnt_ff [8];
   logic [7:0]  flag_ff;
   logic [2:0]  men_ff;
   logic [7:0]  rnd_ff;
   logic        bank_ff;
   logic [31:0] pend_ff;
   logic [FRAC_BITS-1:0] frac_ff;
   logic [1:0]  mode_ff;
   logic [11:0] addr_ff;
   logic [7:0]  wdata_ff;
   logic [PW-1:0] prod_ff;
   logic [31:0] whole_ff;
   logic [1:0]  ch_ff;
   logic [7:0]  rd_ff;
   logic        hit_ff;
   logic        rspv_ff;
   logic        mstart_ff;

   logic [2:0]  idx, fn;
   logic [7:0]  low;
   logic [32:0] pend_sum;
   logic [40:0] part;
   logic [2:0]  x;
   logic [AW-1:0] ram_addr;
   logic [7:0]  ram_q;
   logic        ram_we;
   logic [63:0] clocks;
   mod_req_type mreq;
   mod_rsp_type mrsp;
   logic [8:0]  span;
   logic signed [9:0] nlow;
   logic        wr_hit;
   logic        rnd_clr;

   assign idx = addr_ff[2:0];
   assign fn  = addr_ff[5:3];
   assign low = cnt_ff[idx][7:0];
   assign x   = 3'd5 + {1'b0, ch_ff};
   assign span = {1'b0, top_ff[x]} + 9'd1;
   assign pend_sum = {1'b0, pend_ff} + {17'd0, req_cycles_elapsed};
   assign part = (state_ff == S_MUL_LO) ? pend_ff[15:0] * ratio_ff : pend_ff[31:16] * ratio_ff;
   assign clocks = {{(64-PW){1'b0}}, prod_ff} + {{(64-FRAC_BITS){1'b0}}, frac_ff};
   assign nlow = $signed({2'b00, cnt_ff[x][7:0]}) - $signed({1'b0, mrsp.rem});
   assign wr_hit  = (mode_ff == MODE_WRITE) && (addr_ff >= REG_LIMIT) && (addr_ff < WR_LIMIT);
   assign rnd_clr = wr_hit && (fn == FN_WR_RESET);

   assign ram_we   = (state_ff == S_EXEC) && (mode_ff == MODE_LOAD);
   assign ram_addr = AW'(ram_we ? addr_ff : (12'd2047 - {1'b0, cnt_ff[idx]}));
   assign mreq.start = mstart_ff;
   assign mreq.whole = whole_ff;
   assign mreq.span  = span;

   dfc_ram #(.WIDTH(8), .DEPTH(DISPLAY_BYTES)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(wdata_ff), .rd_data(ram_q)
   );
   dfc_modulo u_mod (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_read_data = rd_ff;
   assign rsp_handled = hit_ff;
   assign rsp_current_bank = bank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ratio_ff <= RATIO_RESET;
         for (int i = 0; i < 8; i++) begin
            top_ff[i] <= '0;
            bot_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
         flag_ff <= '0;
         men_ff <= '0;
         rnd_ff <= 8'd1;
         bank_ff <= 1'b1;
         pend_ff <= '0;
         frac_ff <= '0;
         rspv_ff <= 1'b0;
         mstart_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            ratio_ff <= csr_osc_ratio;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  mode_ff  <= req_mode;
                  addr_ff  <= req_address;
                  wdata_ff <= req_write_data;
                  pend_pick: pend_ff <= pend_sum[32] ? 32'hFFFF_FFFF : pend_sum[31:0];
                  rd_ff <= '0;
                  hit_ff <= 1'b0;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff <= S_RSP;
               if (rnd_clr) begin
                  rnd_ff <= 8'd1;
               end else if (mode_ff == MODE_READ || mode_ff == MODE_WRITE) begin
                  rnd_ff <= {rnd_ff[6:0], ~(rnd_ff[7] ^ rnd_ff[5] ^ rnd_ff[4] ^ rnd_ff[3])};
               end
               if (mode_ff == MODE_READ && addr_ff < REG_LIMIT) begin
                  hit_ff <= 1'b1;
                  if (low == top_ff[idx]) flag_ff[idx] <= 1'b1;
                  else if (low == bot_ff[idx]) flag_ff[idx] <= 1'b0;
                  state_ff <= S_RAM;
               end else if (wr_hit) begin
                  case (fn)
                     FN_WR_TOP: begin
                        top_ff[idx] <= wdata_ff;
                        flag_ff[idx] <= 1'b0;
                     end
                     FN_WR_BOT: bot_ff[idx] <= wdata_ff;
                     FN_WR_LOW: begin
                        if (idx >= 3'd5 && men_ff[2'(idx - 3'd5)])
                           cnt_ff[idx][7:0] <= top_ff[idx];
                        else
                           cnt_ff[idx][7:0] <= wdata_ff;
                     end
                     FN_WR_HIGH: begin
                        cnt_ff[idx][10:8] <= wdata_ff[2:0];
                        if (idx >= 3'd5) men_ff[2'(idx - 3'd5)] <= wdata_ff[4];
                     end
                     default: ;
                  endcase
               end else if (mode_ff == MODE_READ || mode_ff == MODE_WRITE) begin
                  if (addr_ff == HOT_BANK0) bank_ff <= 1'b0;
                  else if (addr_ff == HOT_BANK1) bank_ff <= 1'b1;
               end
            end
            S_RAM: begin
               // flag now updated; rnd_ff already clocked
               state_ff <= S_RSP;
               case (fn)
                  FN_RD_RANDOM: begin
                     if (idx < 3'd4) rd_ff <= rnd_ff;
                     else state_ff <= S_MUL_LO;
                  end
                  FN_RD_DISP: rd_ff <= ram_q;
                  FN_RD_MASK: rd_ff <= ram_q & {8{flag_ff[idx]}};
                  FN_RD_FLAG: rd_ff <= {8{flag_ff[idx]}};
                  default: ;
               endcase
               if (idx < 3'd5 || !men_ff[2'(idx - 3'd5)])
                  cnt_ff[idx] <= cnt_ff[idx] - 11'd1;
            end
            S_MUL_LO: begin
               prod_ff <= PW'(part);
               state_ff <= S_MUL_HI;
            end
            S_MUL_HI: begin
               prod_ff <= prod_ff + (PW'(part) << 16);
               state_ff <= S_SAT;
            end
            S_SAT: begin
               frac_ff <= clocks[FRAC_BITS-1:0];
               pend_ff <= '0;
               whole_ff <= ((clocks >> FRAC_BITS) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                           : clocks[FRAC_BITS +: 32];
               ch_ff <= '0;
               state_ff <= S_CH;
            end
            S_CH: begin
               if (ch_ff == 2'd3 || whole_ff == '0) begin
                  state_ff <= S_AMP;
               end else if (!men_ff[ch_ff]) begin
                  ch_ff <= ch_ff + 2'd1;
               end else if (top_ff[x] == '0) begin
                  flag_ff[x] <= 1'b0;
                  cnt_ff[x][7:0] <= '0;
                  ch_ff <= ch_ff + 2'd1;
               end else begin
                  mstart_ff <= 1'b1;
                  state_ff <= S_MOD;
               end
            end
            S_MOD: begin
               mstart_ff <= 1'b0;
               if (mrsp.done) begin
                  logic [8:0] nl;
                  nl = nlow[9] ? 9'(nlow + $signed({1'b0, span})) : nlow[8:0];
                  if (nl <= {1'b0, bot_ff[x]}) flag_ff[x] <= 1'b0;
                  else if (nl <= {1'b0, top_ff[x]}) flag_ff[x] <= 1'b1;
                  cnt_ff[x][7:0] <= nl[7:0];
                  ch_ff <= ch_ff + 2'd1;
                  state_ff <= S_CH;
               end
            end
            S_AMP: begin
               rd_ff <= amp_lookup(men_ff & flag_ff[7:5]);
               state_ff <= S_RSP;
            end
            S_RSP: begin
               if (!rspv_ff) begin
                  rspv_ff <= 1'b1;
               end else if (rsp_ready) begin
                  rspv_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("response dropped");
   a_hit_only_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_handled |-> mode_ff == MODE_READ) else $error("bad handled");
endmodule
